// File: rtl/krt_pkg.sv
// Package for the keyed record table: record type, command and status codes,
// and the control group that steers the cell chain. No dependencies.
package krt_pkg;

  localparam int IdW    = 16;
  localparam int PriceW = 24;
  localparam int QtyW   = 20;
  localparam int CmdW   = 3;
  localparam int StatW  = 3;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
  } rec_t;

  localparam logic [CmdW-1:0] CMD_ADD    = 3'd0;
  localparam logic [CmdW-1:0] CMD_UPDATE = 3'd1;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 3'd2;
  localparam logic [CmdW-1:0] CMD_DELETE = 3'd3;
  localparam logic [CmdW-1:0] CMD_SCAN   = 3'd4;
  localparam logic [CmdW-1:0] CMD_LIST   = 3'd5;

  localparam logic [StatW-1:0] STAT_OK       = 3'd0;
  localparam logic [StatW-1:0] STAT_FULL     = 3'd1;
  localparam logic [StatW-1:0] STAT_DUP      = 3'd2;
  localparam logic [StatW-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [StatW-1:0] STAT_NONE     = 3'd4;

  typedef logic [1:0] chain_mode_t;
  localparam chain_mode_t CH_HOLD  = 2'd0;
  localparam chain_mode_t CH_ROT   = 2'd1;
  localparam chain_mode_t CH_SHIFT = 2'd2;
  localparam chain_mode_t CH_LOAD  = 2'd3;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_NBR  = 2'd1;
  localparam cell_op_t CELL_LOAD = 2'd2;

  typedef struct packed {
    chain_mode_t mode;
    rec_t        feed;
  } chain_ctrl_t;

endpackage

// File: rtl/krt_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on krt_pkg.
interface krt_in_if;
  import krt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  logic [IdW-1:0]      key_id;
  logic [PriceW-1:0]   price_in;
  logic [PriceW-1:0]   price_upper;
  logic [QtyW-1:0]     qty_in;

  modport source(output valid, cmd, key_id, price_in, price_upper, qty_in, input ready);
  modport sink(input valid, cmd, key_id, price_in, price_upper, qty_in, output ready);
endinterface

interface krt_out_if;
  import krt_pkg::*;
  logic                valid;
  logic                ready;
  logic [StatW-1:0]    status;
  logic [IdW-1:0]      rec_id;
  logic [PriceW-1:0]   rec_price;
  logic [QtyW-1:0]     rec_qty;
  logic                last;

  modport source(output valid, status, rec_id, rec_price, rec_qty, last, input ready);
  modport sink(input valid, status, rec_id, rec_price, rec_qty, last, output ready);
endinterface

// File: rtl/krt_cell.sv
// One table slot: holds a record, takes its neighbor's record or a loaded one.
// Depends on krt_pkg.
module krt_cell
  import krt_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  rec_t     nbr,
  input  rec_t     ld,
  output rec_t     rec
);

  rec_t rec_r;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_NBR:  rec_r <= nbr;
      CELL_LOAD: rec_r <= ld;
      default:   rec_r <= rec_r;
    endcase
  end

  assign rec = rec_r;

endmodule

// File: rtl/krt_chain.sv
// Row of krt_cell slots: rotate toward the head, close a gap, or load a slot.
// Depends on krt_pkg and krt_cell.
module krt_chain
  import krt_pkg::*;
#(
  parameter int CAPACITY = 64,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  chain_ctrl_t   ctrl,
  input  logic [IW-1:0] sel_idx,
  output rec_t          head
);

  rec_t recs [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IW-1:0] MyIdx = IW'(i);
    cell_op_t op;
    rec_t     nbr;

    if (i == CAPACITY - 1) begin : g_tail
      assign nbr = ctrl.feed;
    end else begin : g_mid
      assign nbr = recs[i+1];
    end

    always_comb begin
      unique case (ctrl.mode)
        CH_ROT:   op = CELL_NBR;
        CH_SHIFT: op = (i != CAPACITY - 1 && MyIdx >= sel_idx) ? CELL_NBR : CELL_HOLD;
        CH_LOAD:  op = (MyIdx == sel_idx) ? CELL_LOAD : CELL_HOLD;
        default:  op = CELL_HOLD;
      endcase
    end

    krt_cell u_cell (
      .clk (clk),
      .op  (op),
      .nbr (nbr),
      .ld  (ctrl.feed),
      .rec (recs[i])
    );
  end

  assign head = recs[0];

endmodule

// File: rtl/keyed_record_table_top.sv
// Keyed record table: command sequencer over a rotating chain of record slots.
// Depends on krt_pkg, krt_if, krt_chain.
//
//   channel  dir  handshake             payload
//   in_ch    in   in_ch.valid/ready     cmd, key_id, price_in, price_upper, qty_in
//   out_ch   out  out_ch.valid/ready    status, rec_id, rec_price, rec_qty, last
//
// Every defined command walks the whole chain once: CAPACITY rotate steps plus one
// finish step, which registers the last result; the next item is taken once the
// sequencer is back in idle. Unused codes are accepted without a walk and give no
// result. The walk passes one slot per cycle through the head compare; a full
// turn leaves the order unchanged. Reset empties the table at once.
// A stalled result register pauses the walk; a new item is taken only when idle.
module keyed_record_table_top
  import krt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  krt_in_if.sink    in_ch,
  krt_out_if.source out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CmdW-1:0]   cmd_r;
  logic [IdW-1:0]    key_r;
  logic [PriceW-1:0] plo_r, phi_r;
  logic [QtyW-1:0]   qty_r;
  logic              found_r, found_nxt;
  rec_t              found_rec_r, found_rec_nxt;
  logic [IW-1:0]     found_idx_r, found_idx_nxt;
  logic              pend_v_r, pend_v_nxt;
  rec_t              pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  logic [StatW-1:0]  out_stat_r, out_stat_nxt;
  rec_t              out_rec_r, out_rec_nxt;
  logic              out_last_r, out_last_nxt;

  chain_ctrl_t       ctrl;
  logic [IW-1:0]     sel_idx;
  rec_t              head;
  rec_t              new_rec;
  logic              accept, step_en, live, hit, match, full, out_load;

  krt_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .sel_idx (sel_idx),
    .head    (head)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign step_en     = !out_v_r || out_ch.ready;
  assign live        = (CW'(idx_r) < cnt_r);
  assign hit         = live && (head.id == key_r);
  assign match       = live && ((cmd_r == CMD_LIST) ||
                       ((cmd_r == CMD_SCAN) && (head.price >= plo_r) && (head.price <= phi_r)));
  assign full        = (cnt_r == CW'(CAPACITY));
  assign new_rec     = '{id: key_r, price: plo_r, qty: qty_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    found_rec_nxt = found_rec_r;
    found_idx_nxt = found_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_load      = 1'b0;
    out_stat_nxt  = out_stat_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    ctrl.mode     = CH_HOLD;
    ctrl.feed     = head;
    sel_idx       = found_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
          if (in_ch.cmd <= CMD_LIST) state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (step_en) begin
          ctrl.mode = CH_ROT;
          if (hit && cmd_r == CMD_UPDATE) ctrl.feed.qty = qty_r;
          if (hit) begin
            found_nxt     = 1'b1;
            found_rec_nxt = ctrl.feed;
            found_idx_nxt = idx_r;
          end
          if (match) begin
            if (pend_v_r) begin
              out_load     = 1'b1;
              out_stat_nxt = STAT_OK;
              out_rec_nxt  = pend_r;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = head;
          end
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IW'(CAPACITY - 1)) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (step_en) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          out_rec_nxt  = '0;
          state_nxt    = S_IDLE;
          priority if (cmd_r == CMD_ADD) begin
            if (full) begin
              out_stat_nxt = STAT_FULL;
            end else if (found_r) begin
              out_stat_nxt = STAT_DUP;
              out_rec_nxt  = found_rec_r;
            end else begin
              out_stat_nxt = STAT_OK;
              out_rec_nxt  = new_rec;
              ctrl.mode    = CH_LOAD;
              ctrl.feed    = new_rec;
              sel_idx      = cnt_r[IW-1:0];
              cnt_nxt      = cnt_r + 1'b1;
            end
          end else if (cmd_r == CMD_SCAN || cmd_r == CMD_LIST) begin
            if (pend_v_r) begin
              out_stat_nxt = STAT_OK;
              out_rec_nxt  = pend_r;
            end else begin
              out_stat_nxt = STAT_NONE;
            end
          end else begin
            if (found_r) begin
              out_stat_nxt = STAT_OK;
              out_rec_nxt  = found_rec_r;
              if (cmd_r == CMD_DELETE) begin
                ctrl.mode = CH_SHIFT;
                cnt_nxt   = cnt_r - 1'b1;
              end
            end else begin
              out_stat_nxt = STAT_NOTFOUND;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_v_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      found_r  <= found_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      key_r <= in_ch.key_id;
      plo_r <= in_ch.price_in;
      phi_r <= in_ch.price_upper;
      qty_r <= in_ch.qty_in;
    end
    found_rec_r <= found_rec_nxt;
    found_idx_r <= found_idx_nxt;
    pend_r      <= pend_nxt;
    out_stat_r  <= out_stat_nxt;
    out_rec_r   <= out_rec_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.status    = out_stat_r;
  assign out_ch.rec_id    = out_rec_r.id;
  assign out_ch.rec_price = out_rec_r.price;
  assign out_ch.rec_qty   = out_rec_r.qty;
  assign out_ch.last      = out_last_r;

endmodule
